// ===== design/mbp_pkg.sv =====
// Shared types, constants and helpers of the MSB-first bit packer.
package mbp_pkg;

    localparam int WORD_BITS   = 32;
    localparam int ELEM_BITS   = 64;
    localparam int ACC_BITS    = WORD_BITS + ELEM_BITS;
    localparam int PBITS_W     = 7;
    localparam int CODE_W      = 2;
    localparam int CNT_W       = 5;
    localparam int BYTES_W     = 3;
    localparam int IDX_W       = 2;
    localparam int OUT_TDATA_W = 40;

    // Configuration register indexes.
    localparam logic CFG_PACKED_BITS  = 1'b0;
    localparam logic CFG_SOURCE_WIDTH = 1'b1;

    localparam logic [PBITS_W-1:0] PACKED_BITS_RESET = 7'd8;
    localparam logic [CODE_W-1:0]  SOURCE_CODE_RESET = 2'd0;
    localparam logic [BYTES_W-1:0] FULL_WORD_BYTES   = 3'd4;

    // One accepted element, already left aligned so its first stream bit is bit 63.
    typedef struct packed {
        logic [ELEM_BITS-1:0] aligned;
        logic [PBITS_W-1:0]   packed_bits;
        logic                 final_element;
        logic                 bad_width;
    } t_item;

    // Everything needed to emit the results caused by one element.
    typedef struct packed {
        logic [ACC_BITS-1:0] bits;
        logic [IDX_W-1:0]    full_words;
        logic                bad_width;
        logic                flush;
        logic [BYTES_W-1:0]  flush_bytes;
        logic                final_element;
    } t_batch;

    // Word slot s of the left-aligned 96-bit stream window.
    function automatic logic [WORD_BITS-1:0] slot_word(input logic [ACC_BITS-1:0] bits,
                                                       input logic [IDX_W-1:0]    s);
        logic [WORD_BITS-1:0] w;
        case (s)
            2'd0:    w = bits[ACC_BITS-1 -: WORD_BITS];
            2'd1:    w = bits[ACC_BITS-WORD_BITS-1 -: WORD_BITS];
            default: w = bits[WORD_BITS-1:0];
        endcase
        return w;
    endfunction

    // Bytes needed to hold c bits, rounded up.
    function automatic logic [BYTES_W-1:0] bytes_of(input logic [CNT_W-1:0] c);
        logic [CNT_W:0] s;
        s = {1'b0, c} + (CNT_W+1)'(7);
        return s[CNT_W:3];
    endfunction

endpackage

// ===== design/mbp_in_stage.sv =====
// Configuration registers and the input register that left-aligns each element.
module mbp_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [mbp_pkg::PBITS_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mbp_pkg::ELEM_BITS-1:0] i_element,
    input  logic                          i_final,
    input  logic                          i_free,
    output logic                          o_valid,
    output mbp_pkg::t_item                o_item
);

    logic [mbp_pkg::PBITS_W-1:0] r_packed_bits;
    logic [mbp_pkg::CODE_W-1:0]  r_source_code;
    logic                        r_valid;
    mbp_pkg::t_item              r_item;
    mbp_pkg::t_item              n_item;
    logic [mbp_pkg::PBITS_W-1:0] src_width;
    logic [mbp_pkg::PBITS_W-1:0] lshift;
    logic                        accept;

    assign o_ready = !r_valid || i_free;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        src_width = mbp_pkg::PBITS_W'(8) << r_source_code;
        lshift    = mbp_pkg::PBITS_W'(mbp_pkg::ELEM_BITS) - r_packed_bits;
        // Shifting by 64 - packed_bits drops the unused high bits as well.
        n_item.aligned       = i_element << lshift[5:0];
        n_item.packed_bits   = r_packed_bits;
        n_item.final_element = i_final;
        n_item.bad_width     = (r_packed_bits == '0) || (r_packed_bits > src_width);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packed_bits <= mbp_pkg::PACKED_BITS_RESET;
            r_source_code <= mbp_pkg::SOURCE_CODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbp_pkg::CFG_PACKED_BITS:  r_packed_bits <= i_cfg_data;
                mbp_pkg::CFG_SOURCE_WIDTH: r_source_code <= i_cfg_data[mbp_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_free) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== design/mbp_merge.sv =====
// Leftover-bit state and the merge of one element into a batch of stream words.
module mbp_merge (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbp_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_load,
    output mbp_pkg::t_batch o_batch
);

    localparam int AB = mbp_pkg::ACC_BITS;
    localparam int WB = mbp_pkg::WORD_BITS;

    // Pending bits kept left aligned; the lowest bit of a full word is never pending.
    logic [WB-2:0]              r_left;
    logic [mbp_pkg::CNT_W-1:0]  r_cnt;
    logic [WB-2:0]              n_left;
    logic [mbp_pkg::CNT_W-1:0]  n_cnt;
    logic [AB-1:0]              pending;
    logic [AB-1:0]              merged;
    logic [mbp_pkg::PBITS_W-1:0] total;
    logic [mbp_pkg::CNT_W-1:0]  rem;
    logic [mbp_pkg::IDX_W-1:0]  nfull;
    logic [WB-1:0]              tail;
    logic [mbp_pkg::IDX_W-1:0]  count;

    always_comb begin
        pending = {r_left, 1'b0, {mbp_pkg::ELEM_BITS{1'b0}}};
        merged  = pending | ({i_item.aligned, {WB{1'b0}}} >> r_cnt);
        total   = mbp_pkg::PBITS_W'(r_cnt) + i_item.packed_bits;
        rem     = total[mbp_pkg::CNT_W-1:0];
        nfull   = total[mbp_pkg::PBITS_W-1:mbp_pkg::CNT_W];
        tail    = mbp_pkg::slot_word(merged, nfull);

        o_batch.final_element = i_item.final_element;
        if (i_item.bad_width) begin
            o_batch.bits        = pending;
            o_batch.full_words  = '0;
            o_batch.bad_width   = 1'b1;
            o_batch.flush       = i_item.final_element && (r_cnt != '0);
            o_batch.flush_bytes = mbp_pkg::bytes_of(r_cnt);
        end else begin
            o_batch.bits        = merged;
            o_batch.full_words  = nfull;
            o_batch.bad_width   = 1'b0;
            o_batch.flush       = i_item.final_element && (rem != '0);
            o_batch.flush_bytes = mbp_pkg::bytes_of(rem);
        end

        count  = mbp_pkg::IDX_W'(o_batch.bad_width) + o_batch.full_words
               + mbp_pkg::IDX_W'(o_batch.flush);
        // A valid non-final element that completes no word produces no result at all.
        o_load = i_take && (count != '0);

        n_left = r_left;
        n_cnt  = r_cnt;
        if (i_item.final_element) begin
            n_left = '0;
            n_cnt  = '0;
        end else if (!i_item.bad_width) begin
            n_left = tail[WB-1:1];
            n_cnt  = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_cnt  <= '0;
        end else if (i_take) begin
            r_left <= n_left;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== design/mbp_out_seq.sv =====
// Result register that hands out the words of one batch, one per accepted request.
module mbp_out_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  mbp_pkg::t_batch                 i_batch,
    output logic                            o_free,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mbp_pkg::WORD_BITS-1:0]   o_word,
    output logic [mbp_pkg::BYTES_W-1:0]     o_bytes,
    output logic                            o_eos,
    output logic                            o_err
);

    logic                       r_valid;
    logic [mbp_pkg::IDX_W-1:0]  r_idx;
    mbp_pkg::t_batch            r_batch;
    logic [mbp_pkg::IDX_W-1:0]  total;
    logic [mbp_pkg::IDX_W-1:0]  slot;
    logic                       last;
    logic                       is_err;
    logic                       fire;

    always_comb begin
        total  = mbp_pkg::IDX_W'(r_batch.bad_width) + r_batch.full_words
               + mbp_pkg::IDX_W'(r_batch.flush);
        last   = (r_idx == total - 2'd1);
        slot   = r_idx - mbp_pkg::IDX_W'(r_batch.bad_width);
        is_err = r_batch.bad_width && (r_idx == '0);
        fire   = r_valid && i_ready;

        o_valid = r_valid;
        o_err   = is_err;
        o_eos   = r_batch.final_element && last;
        if (is_err) begin
            o_word  = '0;
            o_bytes = '0;
        end else begin
            o_word  = mbp_pkg::slot_word(r_batch.bits, slot);
            o_bytes = (r_batch.flush && last) ? r_batch.flush_bytes
                                              : mbp_pkg::FULL_WORD_BYTES;
        end
        o_free = !r_valid || (fire && last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (fire && last) begin
            r_valid <= 1'b0;
        end else if (fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_batch <= i_batch;
        end
    end

endmodule

// ===== design/msb_first_bit_packer.sv =====
// Top level of the MSB-first variable-width bit packer.
//
// Each request on the slave stream carries one element in s_axis_tdata and
// marks the last element of a buffer with s_axis_tlast. The low packed_bits
// of the element are appended to the stream, most significant bit first.
// Every 32 gathered bits leave as one big-endian word on the master stream,
// with the valid byte count beside it; the last element flushes the rest as
// a zero-padded word and raises m_axis_tlast on the buffer's final word.
// m_axis_tuser flags a request dropped for a packed width of zero or wider
// than the source width. Registers are written through i_cfg_we; the user
// must write them only while idle; the block does not enforce it. An element
// passes the input and result registers before its first word. One word leaves
// per cycle while m_axis_tready is high, as the port is a single word wide; an
// element gives up to two words, three with a flush, none if not final and
// completing no word. Reset empties the pending bits and restores packed_bits 8
// with 8-bit sources. While the receiver stalls the current word holds, one
// further element waits in the input register, and then s_axis_tready drops.
module msb_first_bit_packer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_index,
    input  logic [mbp_pkg::PBITS_W-1:0]      i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mbp_pkg::ELEM_BITS-1:0]    s_axis_tdata,    // [63:0] element_value
    input  logic                             s_axis_tlast,    // final_element
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mbp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,    // [31:0] stream_word,
                                                              // [34:32] valid_bytes
    output logic                             m_axis_tlast,    // end_of_stream
    output logic                             m_axis_tuser     // config_error
);

    mbp_pkg::t_item                 item;
    mbp_pkg::t_batch                batch;
    logic                           item_valid;
    logic                           free;
    logic                           take;
    logic                           load;
    logic [mbp_pkg::WORD_BITS-1:0]  word;
    logic [mbp_pkg::BYTES_W-1:0]    bytes;

    assign take = item_valid && free;

    mbp_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_element   (s_axis_tdata),
        .i_final     (s_axis_tlast),
        .i_free      (free),
        .o_valid     (item_valid),
        .o_item      (item)
    );

    mbp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_take  (take),
        .o_load  (load),
        .o_batch (batch)
    );

    mbp_out_seq u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_batch (batch),
        .o_free  (free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_word  (word),
        .o_bytes (bytes),
        .o_eos   (m_axis_tlast),
        .o_err   (m_axis_tuser)
    );

    assign m_axis_tdata = {{(mbp_pkg::OUT_TDATA_W - mbp_pkg::WORD_BITS
                             - mbp_pkg::BYTES_W){1'b0}}, bytes, word};

endmodule
